// ----- src/tsfc_pkg.sv -----
`timescale 1ns / 1ps
package tsfc_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int GAIN_W      = 16;
   localparam int SIDE_W      = 12;
   localparam int POS_W       = 12;
   localparam int CNT_W       = 4;
   localparam int DIFF_W      = SAMPLE_W + 1;
   localparam int PROD_W      = DIFF_W + GAIN_W + 1;
   localparam int FRAC_W      = 14;
   localparam int SCALED_W    = PROD_W - 1 - FRAC_W;
   localparam int MAX_SAMPLES_DEF = 10;

   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   // register indexes
   localparam logic [2:0] REG_X_OFFSET    = 3'd0;
   localparam logic [2:0] REG_Y_OFFSET    = 3'd1;
   localparam logic [2:0] REG_X_GAIN      = 3'd2;
   localparam logic [2:0] REG_Y_GAIN      = 3'd3;
   localparam logic [2:0] REG_LONG_SIDE   = 3'd4;
   localparam logic [2:0] REG_SHORT_SIDE  = 3'd5;
   localparam logic [2:0] REG_ORIENTATION = 3'd6;

   typedef enum logic [1:0] {
      ORIENT_LANDSCAPE     = 2'd0,
      ORIENT_PORTRAIT      = 2'd1,
      ORIENT_PORTRAIT_REV  = 2'd2,
      ORIENT_LANDSCAPE_REV = 2'd3
   } orient_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] x_sample;
      logic [SAMPLE_W-1:0] y_sample;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] x_pos;
      logic [POS_W-1:0] y_pos;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic first;
      logic s1_en;
      logic s2_en;
   } lane_ctl_type;

endpackage

// ----- src/tsfc_lane.sv -----
`timescale 1ns / 1ps
module tsfc_lane
   import tsfc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  lane_ctl_type        ctl,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic [SAMPLE_W-1:0] offset,
   input  logic [GAIN_W-1:0]   gain,
   input  logic [SIDE_W-1:0]   side,
   output logic                near,
   output logic [SIDE_W-1:0]   scaled
);

   logic [SAMPLE_W-1:0]      avg_ff, avg_in;
   logic [SAMPLE_W:0]        sum;
   logic [SAMPLE_W-1:0]      next_avg;
   logic [SAMPLE_W-1:0]      delta;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [SCALED_W-1:0]      trunc;

   assign sum      = {1'b0, avg_ff} + {1'b0, sample};
   assign next_avg = sum[SAMPLE_W:1];
   assign delta    = (avg_ff > next_avg) ? (avg_ff - next_avg) : (next_avg - avg_ff);
   assign near     = (delta <= SAMPLE_W'(1));

   always_comb begin
      avg_in = avg_ff;
      if (ctl.accept) begin
         avg_in = ctl.first ? sample : next_avg;
      end
   end

   // the averaged value of a finishing reading is next_avg
   assign diff_in = $signed({1'b0, next_avg}) - $signed({1'b0, offset});
   assign prod_in = diff_ff * $signed({1'b0, gain});

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff <= '0;
      end else begin
         avg_ff <= avg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.s1_en) begin
         diff_ff <= diff_in;
      end
      if (ctl.s2_en) begin
         prod_ff <= prod_in;
      end
   end

   assign trunc = prod_ff[PROD_W-2:FRAC_W];

   // drop negatives, and every value when side is zero, to zero; then clamp to side - 1
   always_comb begin
      if (prod_ff[PROD_W-1] || side == '0) begin
         scaled = '0;
      end else if (trunc >= SCALED_W'(side)) begin
         scaled = side - SIDE_W'(1);
      end else begin
         scaled = trunc[SIDE_W-1:0];
      end
   end

endmodule

// ----- src/tsfc_merge.sv -----
`timescale 1ns / 1ps
module tsfc_merge
   import tsfc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              in_valid,
   input  logic [SIDE_W-1:0] tx,
   input  logic [SIDE_W-1:0] ty,
   input  logic [SIDE_W-1:0] long_side,
   input  logic [SIDE_W-1:0] short_side,
   input  orient_type        orientation,
   output logic              rsp_valid,
   output rsp_type           rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   always_comb begin
      unique case (orientation)
         ORIENT_PORTRAIT: begin
            data_in.x_pos = ty;
            data_in.y_pos = tx;
         end
         ORIENT_PORTRAIT_REV: begin
            data_in.x_pos = short_side - ty;
            data_in.y_pos = long_side - tx;
         end
         ORIENT_LANDSCAPE_REV: begin
            data_in.x_pos = tx;
            data_in.y_pos = short_side - ty;
         end
         default: begin
            data_in.x_pos = long_side - tx;
            data_in.y_pos = ty;
         end
      endcase
   end

   assign valid_in = load ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- src/touch_sample_filter_calibrate.sv -----
`timescale 1ns / 1ps
// Touch sample filter and calibration. Each accepted X/Y sample pair updates
// a running average in the same cycle, so one transaction is taken every
// clock unless input is stalled. A reading ends when both axes move by at
// most one count or after MAX_SAMPLES pairs; its average then runs through
// two lanes, one per axis, that subtract the offset, multiply by the Q2.14
// gain and clamp to the screen side, and a merge stage applies the
// orientation. The position of a finished reading passes the difference,
// product and merge registers in order to the result channel. Input is
// stalled only when all three result stages are full and held.
module touch_sample_filter_calibrate
   import tsfc_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [SAMPLE_W-1:0] x_offset_ff, y_offset_ff;
   logic [GAIN_W-1:0]   x_gain_ff, y_gain_ff;
   logic [SIDE_W-1:0]   long_side_ff, short_side_ff;
   orient_type          orient_ff;
   logic                csr_write;
   logic [2:0]          csr_index;

   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    cnt_next;
   logic                s1_valid_ff, s1_valid_in;
   logic                s2_valid_ff, s2_valid_in;
   logic                out_ready, s2_ready, s1_ready;
   logic                accept, first, done;
   logic                near_x, near_y;
   logic [SIDE_W-1:0]   tx, ty;
   lane_ctl_type        ctl;

   // configuration port
   assign pready    = 1'b1;
   assign csr_index = paddr[4:2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_offset_ff   <= '0;
         y_offset_ff   <= '0;
         x_gain_ff     <= GAIN_W'(16384);
         y_gain_ff     <= GAIN_W'(16384);
         long_side_ff  <= SIDE_W'(320);
         short_side_ff <= SIDE_W'(240);
         orient_ff     <= ORIENT_LANDSCAPE;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_X_OFFSET:    x_offset_ff   <= pwdata[SAMPLE_W-1:0];
            REG_Y_OFFSET:    y_offset_ff   <= pwdata[SAMPLE_W-1:0];
            REG_X_GAIN:      x_gain_ff     <= pwdata[GAIN_W-1:0];
            REG_Y_GAIN:      y_gain_ff     <= pwdata[GAIN_W-1:0];
            REG_LONG_SIDE:   long_side_ff  <= pwdata[SIDE_W-1:0];
            REG_SHORT_SIDE:  short_side_ff <= pwdata[SIDE_W-1:0];
            REG_ORIENTATION: orient_ff     <= orient_type'(pwdata[1:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_index)
         REG_X_OFFSET:    prdata = CSR_DATA_W'(x_offset_ff);
         REG_Y_OFFSET:    prdata = CSR_DATA_W'(y_offset_ff);
         REG_X_GAIN:      prdata = CSR_DATA_W'(x_gain_ff);
         REG_Y_GAIN:      prdata = CSR_DATA_W'(y_gain_ff);
         REG_LONG_SIDE:   prdata = CSR_DATA_W'(long_side_ff);
         REG_SHORT_SIDE:  prdata = CSR_DATA_W'(short_side_ff);
         REG_ORIENTATION: prdata = CSR_DATA_W'(orient_ff);
         default:         prdata = '0;
      endcase
   end

   // result pipeline flow control
   assign out_ready = !rsp_valid || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;
   assign accept    = req_valid && !req_stall;

   // reading sequencer
   assign first    = (cnt_ff == '0);
   assign cnt_next = cnt_ff + CNT_W'(1);
   assign done     = !first && ((near_x && near_y) || (cnt_next >= CNT_W'(MAX_SAMPLES)));

   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         if (first) begin
            cnt_in = CNT_W'(1);
         end else if (done) begin
            cnt_in = '0;
         end else begin
            cnt_in = cnt_next;
         end
      end
   end

   assign s1_valid_in = s1_ready ? (accept && done) : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   assign ctl.accept = accept;
   assign ctl.first  = first;
   assign ctl.s1_en  = s1_ready;
   assign ctl.s2_en  = s2_ready;

   tsfc_lane u_lane_x (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample (req_data.x_sample),
      .offset (x_offset_ff),
      .gain   (x_gain_ff),
      .side   (long_side_ff),
      .near   (near_x),
      .scaled (tx)
   );

   tsfc_lane u_lane_y (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .sample (req_data.y_sample),
      .offset (y_offset_ff),
      .gain   (y_gain_ff),
      .side   (short_side_ff),
      .near   (near_y),
      .scaled (ty)
   );

   tsfc_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .load        (out_ready),
      .in_valid    (s2_valid_ff),
      .tx          (tx),
      .ty          (ty),
      .long_side   (long_side_ff),
      .short_side  (short_side_ff),
      .orientation (orient_ff),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CNT_W'(MAX_SAMPLES))
      else $error("sample count out of range");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && rsp_valid && rsp_stall))
      else $error("input stalled with room in the result pipeline");

   a_first_seed: assert property (@(posedge clock) disable iff (reset)
      (accept && first) |=> (cnt_ff == CNT_W'(1)))
      else $error("first sample did not start a reading");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |=> s1_valid_ff)
      else $error("pending reading lost in first result stage");

   a_done_resets: assert property (@(posedge clock) disable iff (reset)
      (accept && done) |=> (cnt_ff == '0 && s1_valid_ff))
      else $error("finished reading not handed to result pipeline");

endmodule

// ----- bench/tb_touch_sample_filter_calibrate.sv -----
`timescale 1ns / 1ps
module tb_touch_sample_filter_calibrate;
   import tsfc_pkg::*;

   localparam int NUM_PHASES      = 12;
   localparam int PAIRS_PER_PHASE = 120;
   localparam int DRAIN_CYCLES    = 8;
   localparam int NUM_ROWS        = 22;

   typedef enum logic [1:0] {
      ROW_PREDICTED = 2'd0,
      ROW_SILENT    = 2'd1,
      ROW_TYPED     = 2'd2
   } row_kind_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] x;
      logic [SAMPLE_W-1:0] y;
      row_kind_type        kind;
      logic [POS_W-1:0]    want_x;
      logic [POS_W-1:0]    want_y;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // calibration shadow and running averages of the block
   logic [SAMPLE_W-1:0] cfg_x_offset, cfg_y_offset;
   logic [GAIN_W-1:0]   cfg_x_gain, cfg_y_gain;
   logic [SIDE_W-1:0]   cfg_long, cfg_short;
   orient_type          cfg_orient;
   logic [SAMPLE_W-1:0] avg_x, avg_y;
   logic [CNT_W-1:0]    taken_cnt;

   rsp_type pending_positions[$];
   int      error_count;
   int      pairs_sent;
   int      positions_seen;
   int      burst_left;
   int      gap_max;
   int      cycle_count;
   int      stall_run;

   // reset config: offset 0, unit gain, 320 x 240, landscape
   stim_row_type directed_rows [0:NUM_ROWS-1] = '{
      '{12'd0,    12'd0,    ROW_SILENT,    12'd0,   12'd0},
      '{12'd0,    12'd0,    ROW_TYPED,     12'd320, 12'd0},
      '{12'd4095, 12'd4095, ROW_SILENT,    12'd0,   12'd0},
      '{12'd4095, 12'd4095, ROW_TYPED,     12'd1,   12'd239},
      '{12'd100,  12'd200,  ROW_SILENT,    12'd0,   12'd0},
      '{12'd102,  12'd200,  ROW_PREDICTED, 12'd0,   12'd0},
      '{12'd100,  12'd100,  ROW_SILENT,    12'd0,   12'd0},
      '{12'd104,  12'd100,  ROW_SILENT,    12'd0,   12'd0},
      '{12'd102,  12'd100,  ROW_PREDICTED, 12'd0,   12'd0},
      '{12'd0,    12'd4095, ROW_SILENT,    12'd0,   12'd0},
      '{12'd4095, 12'd0,    ROW_SILENT,    12'd0,   12'd0},
      '{12'd0,    12'd4095, ROW_SILENT,    12'd0,   12'd0},
      '{12'd4095, 12'd0,    ROW_SILENT,    12'd0,   12'd0},
      '{12'd0,    12'd4095, ROW_SILENT,    12'd0,   12'd0},
      '{12'd4095, 12'd0,    ROW_SILENT,    12'd0,   12'd0},
      '{12'd0,    12'd4095, ROW_SILENT,    12'd0,   12'd0},
      '{12'd4095, 12'd0,    ROW_SILENT,    12'd0,   12'd0},
      '{12'd0,    12'd4095, ROW_SILENT,    12'd0,   12'd0},
      '{12'd4095, 12'd0,    ROW_PREDICTED, 12'd0,   12'd0},
      '{12'd500,  12'd3000, ROW_SILENT,    12'd0,   12'd0},
      '{12'd501,  12'd1000, ROW_SILENT,    12'd0,   12'd0},
      '{12'd500,  12'd2000, ROW_PREDICTED, 12'd0,   12'd0}
   };

   touch_sample_filter_calibrate dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [POS_W-1:0] calibrate_axis(input logic [SAMPLE_W-1:0] level,
                                                       input logic [SAMPLE_W-1:0] off,
                                                       input logic [GAIN_W-1:0]   gain,
                                                       input logic [SIDE_W-1:0]   side);
      longint prod;
      longint t;
      prod = (longint'(level) - longint'(off)) * longint'(gain);
      t = (prod < 0) ? 0 : (prod >>> FRAC_W);
      if (side == '0) return '0;
      if (t >= longint'(side)) t = longint'(side) - 1;
      return t[POS_W-1:0];
   endfunction

   // Fold one sample pair into the running average; return 1 with the
   // screen position when the reading ends.
   function automatic bit fold_sample(input req_type s, output rsp_type pos);
      logic [SAMPLE_W:0]   sum_x, sum_y;
      logic [SAMPLE_W-1:0] next_x, next_y;
      logic [POS_W-1:0]    tx, ty;
      int                  dx, dy, ox, oy;
      bit                  settled;
      pos = '0;
      if (taken_cnt == '0) begin
         avg_x     = s.x_sample;
         avg_y     = s.y_sample;
         taken_cnt = 4'd1;
         return 1'b0;
      end
      taken_cnt = taken_cnt + 4'd1;
      sum_x  = {1'b0, avg_x} + {1'b0, s.x_sample};
      sum_y  = {1'b0, avg_y} + {1'b0, s.y_sample};
      next_x = sum_x[SAMPLE_W:1];
      next_y = sum_y[SAMPLE_W:1];
      dx = int'(avg_x) - int'(next_x);
      dy = int'(avg_y) - int'(next_y);
      settled = dx >= -1 && dx <= 1 && dy >= -1 && dy <= 1;
      avg_x = next_x;
      avg_y = next_y;
      if (!settled && int'(taken_cnt) < MAX_SAMPLES_DEF) return 1'b0;
      taken_cnt = '0;
      tx = calibrate_axis(avg_x, cfg_x_offset, cfg_x_gain, cfg_long);
      ty = calibrate_axis(avg_y, cfg_y_offset, cfg_y_gain, cfg_short);
      case (cfg_orient)
         ORIENT_PORTRAIT: begin
            ox = int'(ty);
            oy = int'(tx);
         end
         ORIENT_PORTRAIT_REV: begin
            ox = int'(cfg_short) - int'(ty);
            oy = int'(cfg_long) - int'(tx);
         end
         ORIENT_LANDSCAPE_REV: begin
            ox = int'(tx);
            oy = int'(cfg_short) - int'(ty);
         end
         default: begin
            ox = int'(cfg_long) - int'(tx);
            oy = int'(ty);
         end
      endcase
      pos.x_pos = ox[POS_W-1:0];
      pos.y_pos = oy[POS_W-1:0];
      return 1'b1;
   endfunction

   function automatic logic [SAMPLE_W-1:0] near_level(input int base, input int spread);
      int v;
      v = base + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[SAMPLE_W-1:0];
   endfunction

   // setup and access cycle; the caller releases the bus after the last write
   task automatic csr_write(input logic [2:0] idx, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_X_OFFSET:    cfg_x_offset = value[SAMPLE_W-1:0];
         REG_Y_OFFSET:    cfg_y_offset = value[SAMPLE_W-1:0];
         REG_X_GAIN:      cfg_x_gain   = value[GAIN_W-1:0];
         REG_Y_GAIN:      cfg_y_gain   = value[GAIN_W-1:0];
         REG_LONG_SIDE:   cfg_long     = value[SIDE_W-1:0];
         REG_SHORT_SIDE:  cfg_short    = value[SIDE_W-1:0];
         REG_ORIENTATION: cfg_orient   = orient_type'(value[1:0]);
         default: ;
      endcase
   endtask

   task automatic apply_setting(input int xo, input int yo, input int xg, input int yg,
                                input int ls, input int ss, input orient_type orient);
      csr_write(REG_X_OFFSET, xo);
      csr_write(REG_Y_OFFSET, yo);
      csr_write(REG_X_GAIN, xg);
      csr_write(REG_Y_GAIN, yg);
      csr_write(REG_LONG_SIDE, ls);
      csr_write(REG_SHORT_SIDE, ss);
      csr_write(REG_ORIENTATION, 32'(orient));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Drop valid, wait for every expected position, then let the pipe settle.
   task automatic drain_positions();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (pending_positions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_sample(input req_type s, input row_kind_type kind,
                              input rsp_type typed_pos);
      rsp_type pos;
      bit      produced;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gap_max != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (req_stall);
      pairs_sent++;
      produced = fold_sample(s, pos);
      if (kind == ROW_TYPED) pending_positions.push_back(typed_pos);
      else if (kind == ROW_PREDICTED && produced) pending_positions.push_back(pos);
   endtask

   // result side: check each transaction, stall on a pattern that changes mode
   always @(posedge clock) begin : position_check
      rsp_type want;
      int      mode;
      if (reset) begin
         rsp_stall   <= 1'b0;
         cycle_count <= 0;
         stall_run   <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            positions_seen++;
            if (pending_positions.size() == 0) begin
               $error("unexpected position x_pos=%0d y_pos=%0d", rsp_data.x_pos, rsp_data.y_pos);
               error_count++;
            end else begin
               want = pending_positions.pop_front();
               if (rsp_data.x_pos !== want.x_pos) begin
                  $error("x_pos expected %0d actual %0d", want.x_pos, rsp_data.x_pos);
                  error_count++;
               end
               if (rsp_data.y_pos !== want.y_pos) begin
                  $error("y_pos expected %0d actual %0d", want.y_pos, rsp_data.y_pos);
                  error_count++;
               end
            end
         end
         cycle_count <= cycle_count + 1;
         mode = (cycle_count / 300) % 4;
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            2: begin
               if (stall_run > 0) begin
                  rsp_stall <= 1'b1;
                  stall_run <= stall_run - 1;
               end else if ($urandom_range(0, 9) == 0) begin
                  rsp_stall <= 1'b1;
                  stall_run <= $urandom_range(1, 20);
               end else begin
                  rsp_stall <= 1'b0;
               end
            end
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   initial begin : stimulus
      req_type    s;
      rsp_type    typed_pos;
      int         style, spread, base_x, base_y;
      orient_type orient;
      req_valid    <= 1'b0;
      req_data     <= '0;
      psel         <= 1'b0;
      penable      <= 1'b0;
      pwrite       <= 1'b0;
      paddr        <= '0;
      pwdata       <= '0;
      reset        <= 1'b1;
      cfg_x_offset = '0;
      cfg_y_offset = '0;
      cfg_x_gain   = 16'd16384;
      cfg_y_gain   = 16'd16384;
      cfg_long     = 12'd320;
      cfg_short    = 12'd240;
      cfg_orient   = ORIENT_LANDSCAPE;
      avg_x        = '0;
      avg_y        = '0;
      taken_cnt    = '0;
      error_count  = 0;
      pairs_sent   = 0;
      positions_seen = 0;
      burst_left   = 0;
      gap_max      = 4;
      style        = 0;
      spread       = 0;
      base_x       = 0;
      base_y       = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         s.x_sample        = directed_rows[i].x;
         s.y_sample        = directed_rows[i].y;
         typed_pos.x_pos   = directed_rows[i].want_x;
         typed_pos.y_pos   = directed_rows[i].want_y;
         send_sample(s, directed_rows[i].kind, typed_pos);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         // hold the sender until every expected position is back
         drain_positions();
         orient = orient_type'(p % 4);
         case (p)
            0: apply_setting(4095, 4095, 65535, 65535, 2048, 2048, ORIENT_PORTRAIT);
            1: apply_setting(0, 0, 65535, 65535, 1, 1, ORIENT_PORTRAIT_REV);
            2: apply_setting($urandom_range(0, 4095), $urandom_range(0, 4095), 0, 0,
                             2048, 2048, ORIENT_LANDSCAPE_REV);
            3: apply_setting($urandom_range(0, 300), $urandom_range(0, 300), 16384, 16384,
                             0, 0, ORIENT_PORTRAIT_REV);
            default: apply_setting(
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 600),
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 600),
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(8000, 24000),
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(8000, 24000),
               $urandom_range(1, 2048), $urandom_range(1, 2048), orient);
         endcase
         gap_max = (p % 3 == 2) ? 0 : $urandom_range(1, 12);
         for (int n = 0; n < PAIRS_PER_PHASE; n++) begin
            // start of a reading: choose how the touch behaves
            if (taken_cnt == '0) begin
               base_x = $urandom_range(0, 4095);
               base_y = $urandom_range(0, 4095);
               case ($urandom_range(0, 19))
                  0, 1, 2: begin
                     style  = 2;
                     spread = 0;
                  end
                  3, 4, 5: begin
                     style  = 1;
                     spread = $urandom_range(50, 400);
                  end
                  default: begin
                     style  = 0;
                     spread = $urandom_range(0, 3);
                  end
               endcase
            end
            if (style == 2) begin
               s.x_sample = $urandom_range(0, 4095);
               s.y_sample = $urandom_range(0, 4095);
            end else begin
               s.x_sample = near_level(base_x, spread);
               s.y_sample = near_level(base_y, spread);
            end
            send_sample(s, ROW_PREDICTED, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_positions.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("run covered %0d sample pairs and %0d positions over %0d calibration settings",
               pairs_sent, positions_seen, NUM_PHASES + 1);
      $display("settings spanned all four orientations, zero and full gain, zero to 2048 sides");
      if (error_count == 0) begin
         $display("** touch_sample_filter_calibrate: PASSED **");
      end else begin
         $display("** touch_sample_filter_calibrate: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #2ms;
      $display("timeout waiting on the block");
      $display("** touch_sample_filter_calibrate: FAILED **");
      $finish;
   end

endmodule

// ----- sim.f -----
src/tsfc_pkg.sv
src/tsfc_lane.sv
src/tsfc_merge.sv
src/touch_sample_filter_calibrate.sv
bench/tb_touch_sample_filter_calibrate.sv
